// ===== rtl/sbl_pkg.sv =====
// Package for the stable descending length sorter.
// Holds the request and response payload types and the fixed field widths.
// No dependencies.
package sbl_pkg;

   localparam int KEY_W   = 8;
   localparam int INDEX_W = 6;

   typedef struct packed {
      logic [KEY_W-1:0] entry_length;
      logic             final_entry;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic [KEY_W-1:0]   key_length;
      logic               run_end;
   } rsp_type;

endpackage

// ===== rtl/sbl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depth and width are parameters; no dependencies.
module sbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/stable_sort_by_length_desc.sv =====
// In the load state one request is taken per cycle; the request flagged final starts the sorted run.
// A run over N stored entries gives N responses; each costs one scan of the length
// RAM (N reads) followed by the emit state, which waits while the response is stalled.
// Requests stall from the final request until the last response of the run is issued.
// Reset clears the entry count and the control state; the length RAM is not cleared,
// as only entries written since the last run are read.
module stable_sort_by_length_desc #(
   parameter int MAX_ENTRIES    = 64,
   parameter int MAX_KEY_LENGTH = 255
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sbl_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sbl_pkg::rsp_type rsp_data
);
   import sbl_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff,      state_in;
   logic [CNT_W-1:0] cnt_ff,        cnt_in;
   logic [CNT_W-1:0] total_ff,      total_in;
   logic [CNT_W-1:0] rank_ff,       rank_in;
   logic [CNT_W-1:0] issue_ff,      issue_in;
   logic             rd_valid_ff,   rd_valid_in;
   logic [IDX_W-1:0] rd_pos_ff,     rd_pos_in;
   logic             best_valid_ff, best_valid_in;
   logic [KEY_W-1:0] best_key_ff,   best_key_in;
   logic [IDX_W-1:0] best_pos_ff,   best_pos_in;
   logic [KEY_W-1:0] prev_key_ff,   prev_key_in;
   logic [IDX_W-1:0] prev_pos_ff,   prev_pos_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   rsp_type          rsp_data_ff,   rsp_data_in;

   logic             req_fire;
   logic             wr_en;
   logic [KEY_W-1:0] sat_key;
   logic             rd_en;
   logic [KEY_W-1:0] rd_key;
   logic             rsp_free;
   logic             last_rank;
   logic             qualifies;
   logic             better;

   sbl_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_length_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (sat_key),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_key)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire  = req_valid && !req_stall;
   assign sat_key   = (req_data.entry_length > KEY_W'(MAX_KEY_LENGTH)) ?
                      KEY_W'(MAX_KEY_LENGTH) : req_data.entry_length;
   assign wr_en     = req_fire && (cnt_ff < CNT_W'(MAX_ENTRIES));
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < total_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_rank = ((rank_ff + CNT_W'(1)) == total_ff);

   // Entries come out ordered by key descending, then position ascending. An entry is
   // still due if it sorts after the one last sent; the earliest largest wins the scan.
   assign qualifies = (rank_ff == '0) || (rd_key < prev_key_ff) ||
                      ((rd_key == prev_key_ff) && (rd_pos_ff > prev_pos_ff));
   assign better    = !best_valid_ff || (rd_key > best_key_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      rank_in       = rank_ff;
      issue_in      = issue_ff;
      rd_valid_in   = rd_en;
      rd_pos_in     = issue_ff[IDX_W-1:0];
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_pos_in   = best_pos_ff;
      prev_key_in   = prev_key_ff;
      prev_pos_in   = prev_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_data.final_entry) begin
                  state_in      = ST_SCAN;
                  total_in      = wr_en ? (cnt_ff + CNT_W'(1)) : cnt_ff;
                  rank_in       = '0;
                  issue_in      = '0;
                  best_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (qualifies && better) begin
                  best_valid_in = 1'b1;
                  best_key_in   = rd_key;
                  best_pos_in   = rd_pos_ff;
               end
               if (CNT_W'(rd_pos_ff) == (total_ff - CNT_W'(1))) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.entry_index  = INDEX_W'(best_pos_ff);
               rsp_data_in.key_length   = best_key_ff;
               rsp_data_in.run_end      = last_rank;
               prev_key_in              = best_key_ff;
               prev_pos_in              = best_pos_ff;
               rank_in                  = rank_ff + CNT_W'(1);
               issue_in                 = '0;
               best_valid_in            = 1'b0;
               if (last_rank) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         total_ff      <= '0;
         rank_ff       <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         total_ff      <= total_in;
         rank_ff       <= rank_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff   <= rd_pos_in;
      best_key_ff <= best_key_in;
      best_pos_ff <= best_pos_in;
      prev_key_ff <= prev_key_in;
      prev_pos_ff <= prev_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The entry count never runs past the size of the store.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above store size");

   // Reads issued by a scan stay inside the loaded part of the store.
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (CNT_W'(rd_pos_ff) < total_ff))
      else $error("scan read beyond loaded entries");

   // While a run is under way, fewer responses have gone out than entries were loaded.
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (rank_ff < total_ff))
      else $error("response rank beyond run length");

   // Every scan finds an entry still due before a response is sent.
   a_best_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_valid_ff)
      else $error("no entry selected at emission");

   // The last response of a run marks run_end and leaves the count cleared.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_free && last_rank) |=>
         (rsp_valid_ff && rsp_data_ff.run_end && cnt_ff == '0 && state_ff == ST_LOAD))
      else $error("run did not close cleanly");

endmodule

// ===== dv/length_order_checker.sv =====
// Checker for the stable descending length sorter: watches both channels, keeps its own
// copy of the stored lengths and compares every response with the predicted rank order.
// Depends on sbl_pkg for the request and response payload types.
module length_order_checker #(
   parameter int MAX_ENTRIES    = 64,
   parameter int MAX_KEY_LENGTH = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sbl_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sbl_pkg::rsp_type rsp_data,
   output int               outstanding_ranks,
   output int               mismatch_count,
   output int               ranks_checked
);
   import sbl_pkg::*;

   logic [KEY_W-1:0] held_length [MAX_ENTRIES];
   int               held_count   = 0;
   logic [KEY_W-1:0] longest_held = '0;
   rsp_type          ranked_q [$];
   int               mismatches   = 0;
   int               checked      = 0;

   // Loads one request; a final request turns the held lengths into the expected ranks.
   task automatic load_and_rank(input req_type item);
      logic [KEY_W-1:0] key;
      rsp_type          rank;
      int               emitted;
      int               level;
      int               pos;
      key = item.entry_length;
      if (key > MAX_KEY_LENGTH) begin
         key = KEY_W'(MAX_KEY_LENGTH);
      end
      // Once the store is full, further requests leave the count and the longest length alone.
      if (held_count < MAX_ENTRIES) begin
         held_length[held_count] = key;
         held_count++;
         if (key > longest_held) begin
            longest_held = key;
         end
      end
      if (item.final_entry) begin
         emitted = 0;
         for (level = longest_held; level >= 0; level--) begin
            for (pos = 0; pos < held_count; pos++) begin
               if (held_length[pos] == level) begin
                  rank.entry_index = INDEX_W'(pos);
                  rank.key_length  = held_length[pos];
                  rank.run_end     = (emitted + 1 == held_count);
                  ranked_q.push_back(rank);
                  emitted++;
               end
            end
         end
         held_count   = 0;
         longest_held = '0;
      end
   endtask

   task automatic compare_rank(input rsp_type seen);
      rsp_type want;
      if (ranked_q.size() == 0) begin
         $error("response with no rank outstanding: entry_index %0d, key_length %0d",
                seen.entry_index, seen.key_length);
         mismatches++;
      end else begin
         want = ranked_q.pop_front();
         checked++;
         if (seen.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d", want.entry_index, seen.entry_index);
            mismatches++;
         end
         if (seen.key_length !== want.key_length) begin
            $error("key_length: expected %0d, actual %0d", want.key_length, seen.key_length);
            mismatches++;
         end
         if (seen.run_end !== want.run_end) begin
            $error("run_end: expected %0d, actual %0d", want.run_end, seen.run_end);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count   = 0;
         longest_held = '0;
         ranked_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_rank(rsp_data);
         end
         if (req_valid && !req_stall) begin
            load_and_rank(req_data);
         end
      end
      outstanding_ranks <= ranked_q.size();
      mismatch_count    <= mismatches;
      ranks_checked     <= checked;
   end

endmodule

// ===== dv/stable_sort_by_length_desc_tb.sv =====
// Testbench top for the stable descending length sorter: generates runs of length requests
// with random gaps and response back-pressure, and reports the verdict.
// Depends on sbl_pkg, stable_sort_by_length_desc and length_order_checker.
module stable_sort_by_length_desc_tb;
   import sbl_pkg::*;

   localparam int MAX_ENTRIES    = 64;
   localparam int MAX_KEY_LENGTH = 255;
   localparam int TARGET_LENGTHS = 470;
   localparam int HOLD_CYCLES    = 600;
   localparam int TAIL_CYCLES    = 200;
   localparam int CYCLE_LIMIT    = 1_000_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int outstanding_ranks;
   int mismatch_count;
   int ranks_checked;
   int cycle_count   = 0;
   int stored_sent   = 0;
   int ignored_sent  = 0;
   int runs_sent     = 0;
   int overflow_runs = 0;
   int run_fill      = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   logic steady      = 1'b0;

   stable_sort_by_length_desc #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .MAX_KEY_LENGTH(MAX_KEY_LENGTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   length_order_checker #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .MAX_KEY_LENGTH(MAX_KEY_LENGTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .outstanding_ranks(outstanding_ranks),
      .mismatch_count   (mismatch_count),
      .ranks_checked    (ranks_checked)
   );

   always #5 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d ranks outstanding.", outstanding_ranks);
      $display("FAIL");
      $finish;
   end

   // Mostly back-to-back, now and then a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [KEY_W-1:0] pick_length(input int mode);
      int r;
      case (mode)
         0: return KEY_W'($urandom_range(255));
         1: return KEY_W'($urandom_range(3));
         2: begin
            r = $urandom_range(3);
            case (r)
               0: return 8'd0;
               1: return 8'd1;
               2: return 8'd254;
               default: return 8'd255;
            endcase
         end
         default: return KEY_W'($urandom_range(100, 120));
      endcase
   endfunction

   task automatic send_request(input logic [KEY_W-1:0] len, input logic fin);
      req_type item;
      int      gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.entry_length = len;
      item.final_entry  = fin;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (run_fill < MAX_ENTRIES) begin
         stored_sent++;
         run_fill++;
      end else begin
         ignored_sent++;
      end
      if (fin) begin
         run_fill = 0;
         runs_sent++;
      end
   endtask

   // The sender stops offering until every predicted rank has been seen.
   task automatic wait_for_ranks();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding_ranks != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_run(input int size, input int mode);
      int i;
      for (i = 0; i < size; i++) begin
         send_request(pick_length(mode), i == size - 1);
      end
   endtask

   // Response side: random back-pressure, with a long hold whenever the top asks for one.
   initial begin
      int span;
      @(posedge clock);
      forever begin
         if (holds_asked != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            span = HOLD_CYCLES;
         end else if (steady || rsp_stall) begin
            rsp_stall <= 1'b0;
            span = steady ? 1 : $urandom_range(1, 6);
         end else begin
            span = pick_gap();
            if (span == 0) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 6);
            end else begin
               rsp_stall <= 1'b1;
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   initial begin
      int run_no;
      int size;
      int r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A lone final request of each extreme length.
      send_request(8'd0, 1'b1);
      send_request(8'd255, 1'b1);
      // Extremes and duplicates mixed, so that ties must keep their load order; then equal and rising runs.
      send_request(8'd255, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd128, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd255, 1'b1);
      send_request(8'd7, 1'b0);
      send_request(8'd7, 1'b0);
      send_request(8'd7, 1'b1);
      send_request(8'd1, 1'b0);
      send_request(8'd2, 1'b0);
      send_request(8'd3, 1'b0);
      send_request(8'd4, 1'b1);
      wait_for_ranks();

      run_no = 0;
      while (stored_sent < TARGET_LENGTHS) begin
         run_no++;
         r = $urandom_range(99);
         if (r < 55) size = $urandom_range(1, 6);
         else if (r < 88) size = $urandom_range(7, 20);
         else if (r < 97) size = $urandom_range(21, 63);
         else size = MAX_ENTRIES;
         if (run_no == 3) begin
            size = MAX_ENTRIES;
         end
         // Requests past a full store are dropped, but the final one still starts the run.
         if (run_no == 8 || run_no == 20) begin
            size = MAX_ENTRIES + $urandom_range(1, 4);
            overflow_runs++;
         end
         steady = (run_no % 9 == 4);
         if (run_no == 5 || run_no == 30) begin
            holds_asked++;
         end
         send_run(size, $urandom_range(3));
         if (run_no == 12 || $urandom_range(4) == 0) begin
            wait_for_ranks();
         end
      end
      steady = 1'b0;

      wait_for_ranks();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d stored and %0d dropped length requests in %0d sorted runs (%0d overflowing).",
               stored_sent, ignored_sent, runs_sent, overflow_runs);
      $display("Checked %0d ranked responses in %0d cycles.", ranks_checked, cycle_count);
      if (mismatch_count == 0 && outstanding_ranks == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sbl_pkg.sv
rtl/sbl_ram.sv
rtl/stable_sort_by_length_desc.sv
dv/length_order_checker.sv
dv/stable_sort_by_length_desc_tb.sv
